// File: rtl/drc_pkg.sv
`default_nettype none

package drc_pkg;

  localparam int IN_W      = 16;
  localparam int PREFIX_W  = 16;
  localparam int LEVEL_W   = 5;
  localparam int S_TDATA_W = 32;
  localparam int M_TDATA_W = 24;

  // one cover node as it travels from the sequencer to the output register
  typedef struct packed {
    logic                last;
    logic [LEVEL_W-1:0]  level;
    logic [PREFIX_W-1:0] prefix;
  } node_t;

endpackage

`default_nettype wire

// File: rtl/drc_fifo.sv
`default_nettype none

module drc_fifo #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push_valid,
  output logic                  push_ready,
  input  wire logic [WIDTH-1:0] push_data,
  output logic                  pop_valid,
  input  wire logic             pop_ready,
  output logic [WIDTH-1:0]      pop_data
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (count != CW'(DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_data   = mem[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

endmodule

`default_nettype wire

// File: rtl/drc_front.sv
`default_nettype none

module drc_front #(
  parameter int KW = 16
) (
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  input  wire logic [drc_pkg::S_TDATA_W-1:0] s_axis_tdata,
  output logic                               push_valid,
  input  wire logic                          push_ready,
  output logic [2*KW-1:0]                    push_data
);

  logic [KW-1:0] lo;
  logic [KW-1:0] hi;
  logic          empty_range;

  // keys are cut to the key width before anything else
  assign lo = s_axis_tdata[KW-1:0];
  assign hi = s_axis_tdata[drc_pkg::IN_W +: KW];

  // an empty range is taken and dropped here, it never reaches the queue
  assign empty_range   = (lo > hi);
  assign s_axis_tready = push_ready;
  assign push_valid    = s_axis_tvalid && !empty_range;
  assign push_data     = {hi, lo};

endmodule

`default_nettype wire

// File: rtl/drc_back.sv
`default_nettype none

module drc_back #(
  parameter int KW = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          q_valid,
  output logic                               q_ready,
  input  wire logic [2*KW-1:0]               q_data,
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  output logic [drc_pkg::M_TDATA_W-1:0]      m_axis_tdata,
  output logic                               m_axis_tlast
);

  localparam int LW  = $clog2(KW + 1);
  localparam int PAD = drc_pkg::M_TDATA_W - drc_pkg::PREFIX_W - drc_pkg::LEVEL_W;

  logic          busy;
  logic          phase;
  logic [KW-1:0] lo;
  logic [KW-1:0] hi;
  logic [LW-1:0] level;

  logic           p_valid;
  drc_pkg::node_t p_node;
  logic           o_valid;
  drc_pkg::node_t o_node;

  logic           out_free;
  logic           adv;
  logic           gen;
  logic           finish;
  logic [KW-1:0]  gen_key;
  logic           push_p;
  logic [KW-1:0]  lo_inc;
  logic [KW-1:0]  hi_dec;
  drc_pkg::node_t gen_node;
  drc_pkg::node_t p_out;

  assign out_free = !o_valid || m_axis_tready;
  // a step may produce a node only if the pending node has somewhere to go
  assign adv      = !p_valid || out_free;
  assign lo_inc   = lo + KW'(1);
  assign hi_dec   = hi - KW'(1);

  always_comb begin
    gen     = 1'b0;
    finish  = 1'b0;
    gen_key = lo;
    if (busy) begin
      if (lo < hi) begin
        if (!phase) begin
          gen     = lo[0];
          gen_key = lo;
        end else begin
          gen     = !hi[0];
          gen_key = hi;
        end
      end else if (lo == hi) begin
        gen    = 1'b1;
        finish = 1'b1;
      end else begin
        finish = 1'b1;
      end
    end
  end

  always_comb begin
    gen_node.prefix = drc_pkg::PREFIX_W'(gen_key);
    gen_node.level  = drc_pkg::LEVEL_W'(level);
    gen_node.last   = finish;
  end

  // pending node closes the cover when the range ends with no node of its own
  always_comb begin
    p_out      = p_node;
    p_out.last = p_node.last || (busy && finish && !gen);
  end

  // pending node moves out when a newer node arrives or when it ends the cover
  assign push_p = p_valid && out_free && (p_node.last || (busy && (gen || finish)));

  always_ff @(posedge clk) begin
    if (rst) begin
      busy    <= 1'b0;
      phase   <= 1'b0;
      p_valid <= 1'b0;
      o_valid <= 1'b0;
    end else begin
      if (!busy) begin
        if (q_valid) begin
          lo    <= q_data[KW-1:0];
          hi    <= q_data[2*KW-1:KW];
          level <= '0;
          phase <= 1'b0;
          busy  <= 1'b1;
        end
      end else if (adv) begin
        if (finish) begin
          busy <= 1'b0;
        end else if (phase) begin
          lo    <= lo_inc >> 1;
          hi    <= hi_dec >> 1;
          level <= level + LW'(1);
          phase <= 1'b0;
        end else begin
          phase <= 1'b1;
        end
      end

      if (busy && adv && gen) begin
        p_node  <= gen_node;
        p_valid <= 1'b1;
      end else if (push_p) begin
        p_valid <= 1'b0;
      end

      if (push_p) begin
        o_node  <= p_out;
        o_valid <= 1'b1;
      end else if (m_axis_tready) begin
        o_valid <= 1'b0;
      end
    end
  end

  assign q_ready       = !busy;
  assign m_axis_tvalid = o_valid;
  assign m_axis_tdata  = {{PAD{1'b0}}, o_node.level, o_node.prefix};
  assign m_axis_tlast  = o_node.last;

endmodule

`default_nettype wire

// File: rtl/dyadic_range_cover.sv
`default_nettype none

// Best range cover of an inclusive key range. Each input word carries a range
// [range_low, range_high]; keys are cut to KEY_BITS bits (at most 16 count).
// The block answers with the minimal list of aligned dyadic nodes that tile
// the range, one node per output word as prefix and level, tlast on the final
// node. An empty range (low above high) is accepted and gives no words. The
// front takes a word per cycle while its two-entry queue has room; the back
// sequencer looks at one node candidate per cycle while the output is not
// stalled, two per tree level, and one node waits in a holding register so
// that tlast is known before it is shown.
module dyadic_range_cover #(
  parameter int KEY_BITS = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  // s_axis_tdata: range_low [15:0], range_high [31:16]
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  input  wire logic [drc_pkg::S_TDATA_W-1:0] s_axis_tdata,
  // m_axis_tdata: node_prefix [15:0], node_level [20:16], zero [23:21]
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  output logic [drc_pkg::M_TDATA_W-1:0]      m_axis_tdata,
  output logic                               m_axis_tlast
);

  localparam int KW = (KEY_BITS < drc_pkg::IN_W) ? KEY_BITS : drc_pkg::IN_W;

  logic            push_valid;
  logic            push_ready;
  logic [2*KW-1:0] push_data;
  logic            q_valid;
  logic            q_ready;
  logic [2*KW-1:0] q_data;

  drc_front #(.KW(KW)) u_front (
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .push_valid    (push_valid),
    .push_ready    (push_ready),
    .push_data     (push_data)
  );

  drc_fifo #(.WIDTH(2*KW), .DEPTH(2)) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_data   (q_data)
  );

  drc_back #(.KW(KW)) u_back (
    .clk           (clk),
    .rst           (rst),
    .q_valid       (q_valid),
    .q_ready       (q_ready),
    .q_data        (q_data),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

`default_nettype wire

// File: rtl/drc_checker.sv
`default_nettype none

module drc_checker (
  input wire logic                          clk,
  input wire logic                          rst,
  input wire logic                          s_axis_tready,
  input wire logic                          m_axis_tvalid,
  input wire logic                          m_axis_tready,
  input wire logic [drc_pkg::M_TDATA_W-1:0] m_axis_tdata,
  input wire logic                          m_axis_tlast
);

  // stalled word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tlast))
    else $error("output word changed while stalled");

  // no node covers more than the whole key space
  a_level_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[20:16] <= 5'd16)
    else $error("node level out of range");

  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[23:21] == 3'd0)
    else $error("padding bits not zero");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("output word right after reset");

  // queue is empty once reset has been seen
  a_ready_after_reset: assert property (@(posedge clk)
    rst |=> s_axis_tready)
    else $error("input not ready right after reset");

endmodule

bind dyadic_range_cover drc_checker u_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire
